[src/pcpfl_pkg.sv]
package pcpfl_pkg;

  localparam int ADDR_W = 34;
  localparam int STOP_W = 35;
  localparam int CNT_W  = 16;
  localparam int WIDE_W = 40;

  localparam logic [ADDR_W-1:0] START_RESET = 34'h0_8000_0000;
  localparam logic [STOP_W-1:0] STOP_RESET  = 35'h0_8800_0000;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic REG_START = 1'b0;
  localparam logic REG_STOP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_OOM = 2'd1,
    ST_BAD = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_SCAN  = 4'd2,
    OP_OOM   = 4'd3,
    OP_READ  = 4'd4,
    OP_POP   = 4'd5,
    OP_CHECK = 4'd6,
    OP_INDEX = 4'd7,
    OP_PUSH  = 4'd8,
    OP_BADF  = 4'd9,
    OP_EMIT  = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT  = 3'd0,
    C_JUMP  = 3'd1,
    C_HIT   = 3'd2,
    C_MORE  = 3'd3,
    C_BAD   = 3'd4,
    C_FETCH = 3'd5,
    C_EMIT  = 3'd6
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t S_IDLE = 4'd0;
  localparam step_t S_A0   = 4'd1;
  localparam step_t S_A0B  = 4'd2;
  localparam step_t S_OOM  = 4'd3;
  localparam step_t S_A1   = 4'd4;
  localparam step_t S_A2   = 4'd5;
  localparam step_t S_F0   = 4'd6;
  localparam step_t S_F1   = 4'd7;
  localparam step_t S_F2   = 4'd8;
  localparam step_t S_F3   = 4'd9;
  localparam step_t S_BADF = 4'd10;
  localparam step_t S_FIN  = 4'd11;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // control store: one word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      S_IDLE:  w = '{op: OP_LOAD,  cond: C_FETCH, target: S_F0};
      S_A0:    w = '{op: OP_SCAN,  cond: C_HIT,   target: S_A1};
      S_A0B:   w = '{op: OP_NOP,   cond: C_MORE,  target: S_A0};
      S_OOM:   w = '{op: OP_OOM,   cond: C_JUMP,  target: S_FIN};
      S_A1:    w = '{op: OP_READ,  cond: C_NEXT,  target: S_IDLE};
      S_A2:    w = '{op: OP_POP,   cond: C_JUMP,  target: S_FIN};
      S_F0:    w = '{op: OP_CHECK, cond: C_NEXT,  target: S_IDLE};
      S_F1:    w = '{op: OP_INDEX, cond: C_BAD,   target: S_BADF};
      S_F2:    w = '{op: OP_NOP,   cond: C_BAD,   target: S_BADF};
      S_F3:    w = '{op: OP_PUSH,  cond: C_JUMP,  target: S_FIN};
      S_BADF:  w = '{op: OP_BADF,  cond: C_NEXT,  target: S_IDLE};
      S_FIN:   w = '{op: OP_EMIT,  cond: C_EMIT,  target: S_IDLE};
      default: w = '{op: OP_NOP,   cond: C_JUMP,  target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[src/pcpfl_ram.sv]
module pcpfl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32768
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/per_cpu_page_free_list_allocator.sv]
// free: checks the page against the region, pushes its index on the home list; a misaligned or outside page is refused
// allocate: scans from the home list to the next one until a non-empty list is found, then pops its head
// out of memory: reported once the count scan has passed over every list, one list per pass
// next item accepted in the cycle after the result is handed to the output register
// reset (rst_n low, synchronous): all lists empty, region registers at defaults;
// link store is not cleared, no start-up pass
module per_cpu_page_free_list_allocator
  import pcpfl_pkg::*;
#(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [2:0]        in_cpu,
  input  logic [ADDR_W-1:0] in_page_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ADDR_W-1:0] out_granted_address,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [STOP_W-1:0] cfg_data
);

  localparam int SH     = $clog2(PAGE_BYTES);
  localparam int PG_W   = ADDR_W - SH;
  localparam int BASE_W = PG_W + 1;
  localparam int IDX_W  = NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1;
  localparam int LW     = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
  localparam int SCAN_W = $clog2(NUM_CPUS + 1);

  function automatic logic [LW-1:0] home_of(input logic [2:0] cpu);
    logic [4:0] v;
    v = {2'b00, cpu};
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= NUM_CPUS) begin
        v = v - 5'(NUM_CPUS);
      end
    end
    return LW'(v);
  endfunction

  step_t upc_r, upc_nxt;
  ctrl_t cw;

  logic [ADDR_W-1:0] start_r;
  logic [STOP_W-1:0] stop_r;

  logic [CNT_W-1:0] cnt_r   [NUM_CPUS];
  logic [IDX_W-1:0] heads_r [NUM_CPUS];

  logic [ADDR_W-1:0] addr_r;
  logic [LW-1:0]     lst_r;
  logic [SCAN_W-1:0] scan_r;
  logic [BASE_W-1:0] base_r;
  logic [IDX_W-1:0]  idx_r;
  logic              bad_r;
  logic [ADDR_W-1:0] res_addr_r;
  status_t           res_st_r;
  logic              out_valid_r;
  logic [ADDR_W-1:0] out_addr_r;
  status_t           out_st_r;

  logic              in_fire, out_free, hit, more;
  logic [LW-1:0]     lst_nxt;
  logic [BASE_W-1:0] base_calc;
  logic [WIDE_W-1:0] diff, gsum;
  logic [ADDR_W-1:0] gaddr;
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_rdata;

  assign cw        = ucode(upc_r);
  assign in_ready  = (upc_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign hit       = (cnt_r[lst_r] != '0);
  assign more      = (scan_r != '0);
  assign lst_nxt   = (32'(lst_r) == NUM_CPUS - 1) ? '0 : lst_r + LW'(1);

  // first page index of the region, rounded up
  assign base_calc = BASE_W'(start_r >> SH) + BASE_W'(|start_r[SH-1:0]);
  assign diff      = WIDE_W'(addr_r[ADDR_W-1:SH]) - WIDE_W'(base_r);
  assign gsum      = WIDE_W'(base_r) + WIDE_W'(idx_r);
  assign gaddr     = ADDR_W'(gsum << SH);

  assign ram_we = (cw.op == OP_PUSH);
  assign ram_re = (cw.op == OP_READ);

  pcpfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_PAGES)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (heads_r[lst_r]),
    .re    (ram_re),
    .raddr (heads_r[lst_r]),
    .rdata (ram_rdata)
  );

  // step sequencer
  always_comb begin
    case (cw.cond)
      C_NEXT:  upc_nxt = upc_r + step_t'(1);
      C_JUMP:  upc_nxt = cw.target;
      C_HIT:   upc_nxt = hit ? cw.target : upc_r + step_t'(1);
      C_MORE:  upc_nxt = more ? cw.target : upc_r + step_t'(1);
      C_BAD:   upc_nxt = bad_r ? cw.target : upc_r + step_t'(1);
      C_FETCH: begin
        if (!in_fire) begin
          upc_nxt = upc_r;
        end else if (in_kind == KIND_FREE) begin
          upc_nxt = cw.target;
        end else begin
          upc_nxt = upc_r + step_t'(1);
        end
      end
      C_EMIT:  upc_nxt = out_free ? cw.target : upc_r;
      default: upc_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= START_RESET;
      stop_r      <= STOP_RESET;
      for (int i = 0; i < NUM_CPUS; i++) begin
        cnt_r[i]   <= '0;
        heads_r[i] <= '0;
      end
    end else begin
      upc_r <= upc_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START: start_r <= cfg_data[ADDR_W-1:0];
          REG_STOP:  stop_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cw.op == OP_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cw.op)
        OP_READ: cnt_r[lst_r] <= cnt_r[lst_r] - CNT_W'(1);
        OP_POP:  heads_r[lst_r] <= ram_rdata;
        OP_PUSH: begin
          heads_r[lst_r] <= idx_r;
          cnt_r[lst_r]   <= cnt_r[lst_r] + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      OP_LOAD: begin
        if (in_fire) begin
          addr_r <= in_page_address;
          lst_r  <= home_of(in_cpu);
          scan_r <= SCAN_W'(NUM_CPUS);
          base_r <= base_calc;
        end
      end
      OP_SCAN: begin
        if (!hit) begin
          lst_r  <= lst_nxt;
          scan_r <= scan_r - SCAN_W'(1);
        end
      end
      OP_CHECK: begin
        bad_r <= (|addr_r[SH-1:0]) || (addr_r < start_r) ||
                 ({1'b0, addr_r} >= stop_r);
      end
      OP_INDEX: begin
        idx_r <= diff[IDX_W-1:0];
        bad_r <= (diff >= WIDE_W'(NUM_PAGES));
      end
      OP_READ: idx_r <= heads_r[lst_r];
      OP_POP: begin
        res_addr_r <= gaddr;
        res_st_r   <= ST_OK;
      end
      OP_OOM: begin
        res_addr_r <= '0;
        res_st_r   <= ST_OOM;
      end
      OP_PUSH: begin
        res_addr_r <= '0;
        res_st_r   <= ST_OK;
      end
      OP_BADF: begin
        res_addr_r <= '0;
        res_st_r   <= ST_BAD;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_addr_r <= res_addr_r;
          out_st_r   <= res_st_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_granted_address = out_addr_r;
  assign out_status          = out_st_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer did not leave idle after an accepted beat");

  a_list_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r != S_IDLE |-> 32'(lst_r) < NUM_CPUS)
    else $error("list pointer beyond last cpu");

  a_emit_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(upc_r) == S_FIN)
    else $error("result raised outside the final step");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cw.op == OP_READ |-> cnt_r[lst_r] != '0)
    else $error("pop from an empty list");
`endif

endmodule
